FILE: src/bounded_ordered_list_engine_defines.svh
// assertion macros for the bounded ordered list engine
// no dependencies; included by bole_back, which checks its own logic
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BOLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bole assertion failed");

// next-cycle implication, disabled in reset
`define BOLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bole assertion failed");

`endif

FILE: src/bole_pkg.sv
// shared types, request codes and defaults of the bounded ordered list engine
// no dependencies
`default_nettype none

package bole_pkg;

   localparam int DEF_CAPACITY    = 16;
   localparam int DEF_VALUE_WIDTH = 32;

   localparam int TYPE_WIDTH      = 3;
   localparam int POS_WIDTH       = 8;
   localparam int IN_VALUE_WIDTH  = 32;
   localparam int OUT_VALUE_WIDTH = 32;
   localparam int OUT_COUNT_WIDTH = 5;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [TYPE_WIDTH-1:0] REQ_INSERT_AT    = 3'd0;
   localparam logic [TYPE_WIDTH-1:0] REQ_INSERT_FRONT = 3'd1;
   localparam logic [TYPE_WIDTH-1:0] REQ_INSERT_BACK  = 3'd2;
   localparam logic [TYPE_WIDTH-1:0] REQ_DELETE_VALUE = 3'd3;
   localparam logic [TYPE_WIDTH-1:0] REQ_DELETE_AT    = 3'd4;
   localparam logic [TYPE_WIDTH-1:0] REQ_SEARCH       = 3'd5;
   localparam logic [TYPE_WIDTH-1:0] REQ_CLEAR        = 3'd6;
   localparam logic [TYPE_WIDTH-1:0] REQ_DUMP         = 3'd7;

   // classified request as it travels from front to back
   typedef struct packed {
      logic                 ins;
      logic                 pos_front;
      logic                 pos_back;
      logic                 del_pos;
      logic                 del_val;
      logic                 search;
      logic                 clr;
      logic                 dump;
      logic [POS_WIDTH-1:0] pos;
   } op_type;

endpackage

`default_nettype wire

FILE: src/bounded_ordered_list_engine.sv
// each request passes from the queue through the match and execute steps of the back end, and its
// answer is registered; the back end takes the next request from the queue in its execute step;
// a dump gives one result per cycle while the list rotates
// a 2-entry queue holds requests while the back end works; busy is high when it is full
// reset: synchronous, active high, leaves the list empty and the queue drained
// depends on bole_pkg, bole_front and bole_back
`default_nettype none

module bounded_ordered_list_engine
   import bole_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output      logic                              busy,
   input  wire logic [TYPE_WIDTH-1:0]             req_type,
   input  wire logic [POS_WIDTH-1:0]              req_position,
   input  wire logic signed [IN_VALUE_WIDTH-1:0]  req_item_value,
   output      logic                              rsp_valid,
   output      logic                              rsp_ok,
   output      logic                              rsp_found,
   output      logic signed [OUT_VALUE_WIDTH-1:0] rsp_entry_value,
   output      logic [OUT_COUNT_WIDTH-1:0]        rsp_entry_count,
   output      logic                              rsp_is_last
);

   logic                   q_valid;
   logic                   q_pop;
   op_type                 q_op;
   logic [VALUE_WIDTH-1:0] q_value;

   bole_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_position  (req_position),
      .req_item_value(req_item_value),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_op          (q_op),
      .q_value       (q_value)
   );

   bole_back #(
      .CAPACITY   (CAPACITY),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_op           (q_op),
      .q_value        (q_value),
      .rsp_valid      (rsp_valid),
      .rsp_ok         (rsp_ok),
      .rsp_found      (rsp_found),
      .rsp_entry_value(rsp_entry_value),
      .rsp_entry_count(rsp_entry_count),
      .rsp_is_last    (rsp_is_last)
   );

endmodule

`default_nettype wire

FILE: src/bole_front.sv
// front end: accepts requests, classifies them and queues them for the back end
// depends on bole_pkg
`default_nettype none

module bole_front
   import bole_pkg::*;
#(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output      logic                             busy,
   input  wire logic [TYPE_WIDTH-1:0]            req_type,
   input  wire logic [POS_WIDTH-1:0]             req_position,
   input  wire logic signed [IN_VALUE_WIDTH-1:0] req_item_value,
   output      logic                             q_valid,
   input  wire logic                             q_pop,
   output      op_type                           q_op,
   output      logic [VALUE_WIDTH-1:0]           q_value
);

   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   op_type                 op_mem   [QUEUE_DEPTH];
   logic [VALUE_WIDTH-1:0] val_mem  [QUEUE_DEPTH];
   logic [QW-1:0]          head_ff, head_in, tail_ff, tail_in;
   logic [CNTW-1:0]        fill_ff, fill_in;

   op_type                                  cls;
   logic [VALUE_WIDTH+IN_VALUE_WIDTH-1:0]   sext;
   logic                                    push;

   always_comb begin
      cls = '0;
      cls.pos = req_position;
      case (req_type)
         REQ_INSERT_AT: begin
            cls.ins = 1'b1;
         end
         REQ_INSERT_FRONT: begin
            cls.ins = 1'b1;
            cls.pos_front = 1'b1;
         end
         REQ_INSERT_BACK: begin
            cls.ins = 1'b1;
            cls.pos_back = 1'b1;
         end
         REQ_DELETE_VALUE: begin
            cls.del_val = 1'b1;
         end
         REQ_DELETE_AT: begin
            cls.del_pos = 1'b1;
         end
         REQ_SEARCH: begin
            cls.search = 1'b1;
         end
         REQ_CLEAR: begin
            cls.clr = 1'b1;
         end
         REQ_DUMP: begin
            cls.dump = 1'b1;
         end
         default: begin
            cls.dump = 1'b1;
         end
      endcase
   end

   assign sext = {{VALUE_WIDTH{req_item_value[IN_VALUE_WIDTH-1]}}, req_item_value};

   assign busy    = (fill_ff == CNTW'(QUEUE_DEPTH));
   assign push    = start && !busy;
   assign q_valid = (fill_ff != '0);
   assign q_op    = op_mem[head_ff];
   assign q_value = val_mem[head_ff];

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (push) begin
         tail_in = (tail_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QW'(1);
      end
      if (q_pop) begin
         head_in = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QW'(1);
      end
      if (push && !q_pop) begin
         fill_in = fill_ff + CNTW'(1);
      end else if (!push && q_pop) begin
         fill_in = fill_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_mem[tail_ff]  <= cls;
         val_mem[tail_ff] <= sext[VALUE_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

FILE: src/bole_back.sv
// back end: row of list cells, request sequencer and result register
// depends on bole_pkg and bounded_ordered_list_engine_defines.svh
`default_nettype none
`include "bounded_ordered_list_engine_defines.svh"

module bole_back
   import bole_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_valid,
   output      logic                              q_pop,
   input  wire op_type                            q_op,
   input  wire logic [VALUE_WIDTH-1:0]            q_value,
   output      logic                              rsp_valid,
   output      logic                              rsp_ok,
   output      logic                              rsp_found,
   output      logic signed [OUT_VALUE_WIDTH-1:0] rsp_entry_value,
   output      logic [OUT_COUNT_WIDTH-1:0]        rsp_entry_count,
   output      logic                              rsp_is_last
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_WIDTH) ? CW : POS_WIDTH;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MATCH = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;
   localparam logic [1:0] ST_DUMP  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0] cells_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0] cells_in [CAPACITY];
   logic [VALUE_WIDTH-1:0] nb_up    [CAPACITY];
   logic [VALUE_WIDTH-1:0] nb_dn    [CAPACITY];
   op_type                 op_ff, op_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [CAPACITY-1:0]    match_ff, match_in;
   logic [CMPW-1:0]        pos_ff, pos_in;
   logic                   okc_ff, okc_in;

   logic                          rv_ff, rv_in;
   logic                          rok_ff, rok_in;
   logic                          rfound_ff, rfound_in;
   logic [OUT_VALUE_WIDTH-1:0]    rval_ff, rval_in;
   logic [OUT_COUNT_WIDTH-1:0]    rcnt_ff, rcnt_in;
   logic                          rlast_ff, rlast_in;

   logic [CMPW-1:0]                  count_w, qpos_w;
   logic [CAPACITY-1:0]              first_m, below_m;
   logic                             found_any, dump_last;
   logic [VALUE_WIDTH+OUT_VALUE_WIDTH-1:0] head_zx;
   logic [CW+OUT_COUNT_WIDTH-1:0]    cnt_zx;

   // neighbor taps of the cell row
   for (genvar g = 0; g < CAPACITY; g++) begin : g_nb
      if (g < CAPACITY - 1) begin : g_up
         assign nb_up[g] = cells_ff[g+1];
      end else begin : g_up_end
         assign nb_up[g] = cells_ff[g];
      end
      if (g > 0) begin : g_dn
         assign nb_dn[g] = cells_ff[g-1];
      end else begin : g_dn_end
         assign nb_dn[g] = cells_ff[g];
      end
   end

   assign count_w   = CMPW'(count_ff);
   assign qpos_w    = CMPW'(op_ff.pos);
   assign found_any = |match_ff;
   assign first_m   = match_ff & (~match_ff + CAPACITY'(1));
   assign below_m   = first_m - CAPACITY'(1);
   assign head_zx   = {{OUT_VALUE_WIDTH{1'b0}}, cells_ff[0]};
   assign dump_last = (count_ff == '0) || (idx_ff == count_ff - CW'(1));
   assign q_pop     = q_valid && ((state_ff == ST_IDLE) || (state_ff == ST_EXEC) ||
                                  ((state_ff == ST_DUMP) && dump_last));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      match_in  = match_ff;
      pos_in    = pos_ff;
      okc_in    = okc_ff;
      rv_in     = 1'b0;
      rok_in    = 1'b1;
      rfound_in = 1'b0;
      rval_in   = '0;
      rlast_in  = 1'b1;
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
      end

      case (state_ff)
         ST_IDLE: begin
         end
         ST_MATCH: begin
            for (int i = 0; i < CAPACITY; i++) begin
               match_in[i] = (CW'(i) < count_ff) && (cells_ff[i] == val_ff);
            end
            if (op_ff.pos_front) begin
               pos_in = '0;
            end else if (op_ff.pos_back) begin
               pos_in = count_w;
            end else begin
               pos_in = qpos_w;
            end
            if (op_ff.ins) begin
               okc_in = (count_ff < CW'(CAPACITY)) && (pos_in <= count_w);
            end else if (op_ff.del_pos) begin
               okc_in = qpos_w < count_w;
            end else begin
               okc_in = 1'b1;
            end
            idx_in   = '0;
            state_in = op_ff.dump ? ST_DUMP : ST_EXEC;
         end
         ST_EXEC: begin
            if (op_ff.ins && okc_ff) begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (CMPW'(i) == pos_ff) begin
                     cells_in[i] = val_ff;
                  end else if (CMPW'(i) > pos_ff) begin
                     cells_in[i] = nb_dn[i];
                  end
               end
               count_in = count_ff + CW'(1);
            end
            if (op_ff.del_pos && okc_ff) begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (CMPW'(i) >= pos_ff) begin
                     cells_in[i] = nb_up[i];
                  end
               end
               count_in = count_ff - CW'(1);
            end
            if (op_ff.del_val && found_any) begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (!below_m[i]) begin
                     cells_in[i] = nb_up[i];
                  end
               end
               count_in = count_ff - CW'(1);
            end
            if (op_ff.clr) begin
               count_in = '0;
            end
            rv_in     = 1'b1;
            rok_in    = okc_ff;
            rfound_in = (op_ff.del_val || op_ff.search) && found_any;
            state_in  = ST_IDLE;
         end
         ST_DUMP: begin
            rv_in = 1'b1;
            if (count_ff == '0) begin
               rok_in = 1'b0;
            end else begin
               rval_in  = head_zx[OUT_VALUE_WIDTH-1:0];
               rlast_in = dump_last;
               // rotate the occupied cells so the list is back in order after the pass
               for (int i = 0; i < CAPACITY; i++) begin
                  if (CW'(i) == count_ff - CW'(1)) begin
                     cells_in[i] = cells_ff[0];
                  end else if (CW'(i) < count_ff - CW'(1)) begin
                     cells_in[i] = nb_up[i];
                  end
               end
               idx_in = idx_ff + CW'(1);
            end
            if (dump_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (q_pop) begin
         op_in    = q_op;
         val_in   = q_value;
         state_in = ST_MATCH;
      end
   end

   assign cnt_zx  = {{OUT_COUNT_WIDTH{1'b0}}, count_in};
   assign rcnt_in = cnt_zx[OUT_COUNT_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_ff[i] <= cells_in[i];
      end
      op_ff     <= op_in;
      val_ff    <= val_in;
      match_ff  <= match_in;
      pos_ff    <= pos_in;
      okc_ff    <= okc_in;
      rok_ff    <= rok_in;
      rfound_ff <= rfound_in;
      rval_ff   <= rval_in;
      rcnt_ff   <= rcnt_in;
      rlast_ff  <= rlast_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_ok          = rok_ff;
   assign rsp_found       = rfound_ff;
   assign rsp_entry_value = rval_ff;
   assign rsp_entry_count = rcnt_ff;
   assign rsp_is_last     = rlast_ff;

   `BOLE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `BOLE_ASSERT_NEXT(a_dump_continues, clock, reset, rv_ff && !rlast_ff, rv_ff)
   `BOLE_ASSERT_NEXT(a_pop_starts_match, clock, reset, q_pop, state_ff == ST_MATCH)
   `BOLE_ASSERT_NEXT(a_exec_emits, clock, reset, state_ff == ST_EXEC, rv_ff && rlast_ff)

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for bounded_ordered_list_engine: directed rows, then random bursts
// keeps a shadow copy of the list and checks every response transfer in order
// depends on bole_pkg and the bounded_ordered_list_engine rtl
module testbench;
   import bole_pkg::*;

   localparam int CAPACITY      = DEF_CAPACITY;
   localparam int RANDOM_ITEMS  = 312;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 24;
   localparam int ROW_COUNT     = 25;

   typedef struct packed {
      logic                       ok;
      logic                       found;
      logic [OUT_VALUE_WIDTH-1:0] value;
      logic [OUT_COUNT_WIDTH-1:0] count;
      logic                       last;
   } list_answer_type;

   typedef struct packed {
      logic [TYPE_WIDTH-1:0]      kind;
      logic [POS_WIDTH-1:0]       pos;
      logic [IN_VALUE_WIDTH-1:0]  value;
      logic [4:0]                 reps;
      logic                       typed;
      logic                       ok;
      logic                       found;
      logic [OUT_COUNT_WIDTH-1:0] count;
   } stim_row_type;

   // typed rows carry their single answer; the others are checked against the shadow list
   localparam stim_row_type DIRECTED_ROWS[ROW_COUNT] = '{
      '{REQ_DUMP,         8'd0,   32'd0,         5'd1,  1'b1, 1'b0, 1'b0, 5'd0},
      '{REQ_DELETE_AT,    8'd0,   32'd0,         5'd1,  1'b1, 1'b0, 1'b0, 5'd0},
      '{REQ_SEARCH,       8'd0,   32'd5,         5'd1,  1'b1, 1'b1, 1'b0, 5'd0},
      '{REQ_DELETE_VALUE, 8'd0,   32'd7,         5'd1,  1'b1, 1'b1, 1'b0, 5'd0},
      '{REQ_INSERT_AT,    8'd1,   32'd9,         5'd1,  1'b1, 1'b0, 1'b0, 5'd0},
      '{REQ_INSERT_AT,    8'd0,   32'h7FFF_FFFF, 5'd1,  1'b1, 1'b1, 1'b0, 5'd1},
      '{REQ_INSERT_FRONT, 8'd0,   32'h8000_0000, 5'd1,  1'b1, 1'b1, 1'b0, 5'd2},
      '{REQ_INSERT_BACK,  8'd0,   32'hFFFF_FFFF, 5'd1,  1'b1, 1'b1, 1'b0, 5'd3},
      '{REQ_INSERT_AT,    8'd255, 32'd1,         5'd1,  1'b1, 1'b0, 1'b0, 5'd3},
      '{REQ_INSERT_AT,    8'd3,   32'd0,         5'd1,  1'b1, 1'b1, 1'b0, 5'd4},
      '{REQ_SEARCH,       8'd0,   32'h8000_0000, 5'd1,  1'b1, 1'b1, 1'b1, 5'd4},
      '{REQ_DUMP,         8'd0,   32'd0,         5'd1,  1'b0, 1'b0, 1'b0, 5'd0},
      '{REQ_DELETE_VALUE, 8'd0,   32'hFFFF_FFFF, 5'd1,  1'b1, 1'b1, 1'b1, 5'd3},
      '{REQ_DELETE_VALUE, 8'd0,   32'd12345,     5'd1,  1'b1, 1'b1, 1'b0, 5'd3},
      '{REQ_DELETE_AT,    8'd255, 32'd0,         5'd1,  1'b1, 1'b0, 1'b0, 5'd3},
      '{REQ_DELETE_AT,    8'd1,   32'd0,         5'd1,  1'b1, 1'b1, 1'b0, 5'd2},
      '{REQ_INSERT_BACK,  8'd0,   32'h5A5A_0000, 5'd14, 1'b0, 1'b0, 1'b0, 5'd0},
      '{REQ_INSERT_FRONT, 8'd0,   32'd3,         5'd1,  1'b1, 1'b0, 1'b0, 5'd16},
      '{REQ_INSERT_AT,    8'd16,  32'd3,         5'd1,  1'b1, 1'b0, 1'b0, 5'd16},
      '{REQ_INSERT_BACK,  8'd0,   32'd3,         5'd1,  1'b1, 1'b0, 1'b0, 5'd16},
      '{REQ_DUMP,         8'd0,   32'd0,         5'd1,  1'b0, 1'b0, 1'b0, 5'd0},
      '{REQ_DELETE_AT,    8'd15,  32'd0,         5'd1,  1'b1, 1'b1, 1'b0, 5'd15},
      '{REQ_DELETE_AT,    8'd0,   32'd0,         5'd1,  1'b1, 1'b1, 1'b0, 5'd14},
      '{REQ_CLEAR,        8'd0,   32'd0,         5'd1,  1'b1, 1'b1, 1'b0, 5'd0},
      '{REQ_DUMP,         8'd0,   32'd0,         5'd1,  1'b1, 1'b0, 1'b0, 5'd0}
   };

   localparam logic [TYPE_WIDTH-1:0] INSERT_KINDS[3] =
      '{REQ_INSERT_AT, REQ_INSERT_FRONT, REQ_INSERT_BACK};
   localparam logic [TYPE_WIDTH-1:0] PROBE_KINDS[3] =
      '{REQ_DELETE_VALUE, REQ_DELETE_AT, REQ_SEARCH};
   localparam logic [IN_VALUE_WIDTH-1:0] EDGE_VALUES[5] =
      '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};

   logic                              clock;
   logic                              reset          = 1'b1;
   logic                              start          = 1'b0;
   logic [TYPE_WIDTH-1:0]             req_type       = '0;
   logic [POS_WIDTH-1:0]              req_position   = '0;
   logic signed [IN_VALUE_WIDTH-1:0]  req_item_value = '0;
   logic                              busy;
   logic                              rsp_valid;
   logic                              rsp_ok;
   logic                              rsp_found;
   logic signed [OUT_VALUE_WIDTH-1:0] rsp_entry_value;
   logic [OUT_COUNT_WIDTH-1:0]        rsp_entry_count;
   logic                              rsp_is_last;

   logic [IN_VALUE_WIDTH-1:0] shadow_list[$];
   list_answer_type           predicted[$];
   list_answer_type           awaited[$];

   int items_sent       = 0;
   int dumps_sent       = 0;
   int rejected_inserts = 0;
   int results_checked  = 0;
   int fail_count       = 0;
   int stall_cycles     = 0;

   bounded_ordered_list_engine #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (DEF_VALUE_WIDTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_found       (rsp_found),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_last     (rsp_is_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // applies one request to the shadow list and fills predicted with its answers
   function automatic void apply_list_request(input logic [TYPE_WIDTH-1:0] kind,
                                              input logic [POS_WIDTH-1:0] pos,
                                              input logic [IN_VALUE_WIDTH-1:0] value);
      int   slot;
      int   hit;
      logic ok;
      logic found;
      ok    = 1'b1;
      found = 1'b0;
      hit   = -1;
      predicted.delete();
      for (int i = 0; i < shadow_list.size(); i++)
         if (hit < 0 && shadow_list[i] == value) hit = i;
      case (kind)
         REQ_INSERT_AT, REQ_INSERT_FRONT, REQ_INSERT_BACK: begin
            slot = (kind == REQ_INSERT_AT) ? int'(pos) :
                   (kind == REQ_INSERT_FRONT) ? 0 : shadow_list.size();
            if (shadow_list.size() >= CAPACITY || slot > shadow_list.size()) begin
               ok = 1'b0;
               rejected_inserts++;
            end else begin
               shadow_list.insert(slot, value);
            end
         end
         REQ_DELETE_VALUE: begin
            found = (hit >= 0);
            if (found) shadow_list.delete(hit);
         end
         REQ_DELETE_AT: begin
            if (pos < shadow_list.size()) shadow_list.delete(int'(pos));
            else ok = 1'b0;
         end
         REQ_SEARCH: found = (hit >= 0);
         REQ_CLEAR: shadow_list.delete();
         default: begin
            if (shadow_list.size() == 0)
               predicted.push_back('{1'b0, 1'b0, 32'd0, 5'd0, 1'b1});
            for (int i = 0; i < shadow_list.size(); i++)
               predicted.push_back('{1'b1, 1'b0, shadow_list[i],
                                     OUT_COUNT_WIDTH'(shadow_list.size()),
                                     (i == shadow_list.size() - 1)});
         end
      endcase
      if (kind != REQ_DUMP)
         predicted.push_back('{ok, found, 32'd0, OUT_COUNT_WIDTH'(shadow_list.size()), 1'b1});
   endfunction

   task automatic issue_request(input logic [TYPE_WIDTH-1:0] kind,
                                input logic [POS_WIDTH-1:0] pos,
                                input logic [IN_VALUE_WIDTH-1:0] value,
                                input logic typed,
                                input list_answer_type answer);
      start          <= 1'b1;
      req_type       <= kind;
      req_position   <= pos;
      req_item_value <= value;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      apply_list_request(kind, pos, value);
      if (typed) awaited.push_back(answer);
      else foreach (predicted[i]) awaited.push_back(predicted[i]);
      items_sent++;
      if (kind == REQ_DUMP) dumps_sent++;
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (awaited.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 50)
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // response monitor and stall counter
   always @(posedge clock) begin
      list_answer_type want;
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (!reset && rsp_valid !== 1'b0) begin
         if (awaited.size() == 0) begin
            fail_count++;
            if (fail_count <= 50)
               $display("%0t ns: unexpected response, expected none, actual ok=%b value=%h",
                        $time, rsp_ok, rsp_entry_value);
         end else begin
            want = awaited.pop_front();
            results_checked++;
            check_field("ok", want.ok, rsp_ok);
            check_field("found", want.found, rsp_found);
            check_field("entry_value", want.value, rsp_entry_value);
            check_field("entry_count", want.count, rsp_entry_count);
            check_field("is_last", want.last, rsp_is_last);
         end
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      list_answer_type           row_answer;
      int                        random_goal;
      int                        burst_len;
      int                        mode;
      int                        roll;
      int                        pick;
      int                        ins_share;
      int                        del_share;
      bit                        drained_once;
      logic [TYPE_WIDTH-1:0]     kind;
      logic [POS_WIDTH-1:0]      pos;
      logic [IN_VALUE_WIDTH-1:0] value;
      drained_once = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < ROW_COUNT; r++) begin
         row_answer = '{DIRECTED_ROWS[r].ok, DIRECTED_ROWS[r].found, 32'd0,
                        DIRECTED_ROWS[r].count, 1'b1};
         for (int k = 0; k < DIRECTED_ROWS[r].reps; k++) begin
            issue_request(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].pos,
                          DIRECTED_ROWS[r].value + k, DIRECTED_ROWS[r].typed, row_answer);
            idle_sender($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
         end
      end

      // bursts lean toward growing, shrinking or mixed traffic
      random_goal = items_sent + RANDOM_ITEMS;
      while (items_sent < random_goal) begin
         burst_len = $urandom_range(1, 16);
         mode      = $urandom_range(0, 2);
         ins_share = (mode == 0) ? 70 : (mode == 1) ? 20 : 45;
         del_share = (mode == 0) ? 20 : (mode == 1) ? 60 : 35;
         repeat (burst_len) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_share) kind = INSERT_KINDS[$urandom_range(0, 2)];
            else if (roll < ins_share + del_share) kind = PROBE_KINDS[$urandom_range(0, 2)];
            else if (roll < 97) kind = REQ_DUMP;
            else kind = REQ_CLEAR;
            pick = $urandom_range(0, 99);
            if (pick < 40 && shadow_list.size() != 0)
               value = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
            else if (pick < 55) value = EDGE_VALUES[$urandom_range(0, 4)];
            else if (pick < 70) value = $urandom_range(0, 7);
            else value = $urandom;
            if ($urandom_range(0, 9) < 7) pos = POS_WIDTH'($urandom_range(0, shadow_list.size() + 1));
            else pos = POS_WIDTH'($urandom_range(0, 255));
            issue_request(kind, pos, value, 1'b0, '0);
         end
         if ((!drained_once && items_sent * 2 >= random_goal) || $urandom_range(0, 9) == 0) begin
            drain_results();
            drained_once = 1'b1;
         end
         idle_sender($urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d requests including %0d dumps and %0d rejected inserts",
               items_sent, dumps_sent, rejected_inserts);
      $display("checked %0d response transfers, %0d mismatches", results_checked, fail_count);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
